### hdl/pfi_pkg.sv
// ----------------------------------------------------------------------------
// pfi_pkg: shared types, constants and functions
// Transfer payloads, fault and mode codes, and the LCG and roll helpers.
// ----------------------------------------------------------------------------
package pfi_pkg;

    localparam int NUM_FAULTS       = 7;
    localparam int CFG_INDEX_WIDTH  = 3;
    localparam int CFG_DATA_WIDTH   = 32;
    localparam int ROLL_WIDTH       = 10;

    localparam logic [31:0] LCG_MUL          = 32'd1103515245;
    localparam logic [31:0] LCG_INC          = 32'd12345;
    localparam logic [31:0] LCG_SEED         = 32'd12345;
    localparam logic [14:0] ROLL_RECIP       = 15'd16777;
    localparam logic [15:0] ROLL_MOD         = 16'd1000;
    localparam logic [31:0] SETUP_MASK_SHORT = 32'h00FF_FFFF;
    localparam logic [31:0] RAM_SETUP_RESET  = 32'hFF00_0000;
    localparam logic [31:0] FILL_PATTERN     = 32'hAAAA_AAAA;
    localparam logic [7:0]  ANY_BLOCK        = 8'hFF;

    typedef enum logic [2:0] {
        MODE_AFTER_READ   = 3'd0,
        MODE_BEFORE_WRITE = 3'd1,
        MODE_AFTER_WRITE  = 3'd2,
        MODE_CRC          = 3'd3,
        MODE_VERIFY       = 3'd4,
        MODE_RAM_MIRROR   = 3'd5
    } mode_t;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        FAULT_SINGLE = 3'd0,
        FAULT_MULTI  = 3'd1,
        FAULT_ERASE  = 3'd2,
        FAULT_POWER  = 3'd3,
        FAULT_CRC    = 3'd4,
        FAULT_VERIFY = 3'd5,
        FAULT_RAM    = 3'd6
    } fault_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] data_in;
        logic [15:0] length;
        logic [15:0] crc_in;
        logic [7:0]  expected_byte;
        logic [7:0]  block_num;
    } in_t;

    typedef struct packed {
        logic        injected;
        logic [31:0] data_out;
        logic [15:0] crc_out;
        logic [7:0]  actual_out;
        logic        fill_all;
        logic [31:0] fault_total;
    } out_t;

    typedef struct packed {
        logic [ROLL_WIDTH-1:0] roll_first;
        logic [ROLL_WIDTH-1:0] roll_second;
    } roll_pair_t;

    function automatic logic [31:0] mul_lo(logic [31:0] a, logic [31:0] b);
        logic [63:0] p;
        p = 64'(a) * 64'(b);
        return p[31:0];
    endfunction

    function automatic logic [31:0] lcg_step(logic [31:0] s);
        return mul_lo(s, LCG_MUL) + LCG_INC;
    endfunction

    function automatic logic [ROLL_WIDTH-1:0] roll_of(logic [31:0] s);
        logic [15:0] x;
        logic [30:0] prod;
        logic [6:0]  q;
        logic [15:0] rem;
        x    = s[31:16];
        prod = 31'(x) * 31'(ROLL_RECIP);
        q    = prod[30:24];
        rem  = x - 16'(16'(q) * ROLL_MOD);
        if (rem >= ROLL_MOD)
        begin
            rem = rem - ROLL_MOD;
        end
        return rem[ROLL_WIDTH-1:0];
    endfunction

    localparam logic [31:0] LCG_MUL2 = mul_lo(LCG_MUL, LCG_MUL);
    localparam logic [31:0] LCG_INC2 = mul_lo(LCG_INC, LCG_MUL + 32'd1);

    localparam logic [31:0] LCG_S1 = lcg_step(LCG_SEED);
    localparam logic [31:0] LCG_S2 = lcg_step(LCG_S1);
    localparam logic [31:0] LCG_S3 = lcg_step(LCG_S2);
    localparam logic [31:0] LCG_S4 = lcg_step(LCG_S3);

    localparam logic [ROLL_WIDTH-1:0] ROLL1_INIT = roll_of(LCG_S1);
    localparam logic [ROLL_WIDTH-1:0] ROLL2_INIT = roll_of(LCG_S2);

endpackage

### hdl/pfi_rng.sv
// ----------------------------------------------------------------------------
// pfi_rng: look-ahead LCG roll source
// Holds the rolls of the next two draws and the states of the two after,
// and advances by zero, one or two draws per cycle.
// ----------------------------------------------------------------------------
module pfi_rng
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [1:0]          draw_count,
    output pfi_pkg::roll_pair_t rolls
);

    logic [pfi_pkg::ROLL_WIDTH-1:0] r1_reg, r1_next;
    logic [pfi_pkg::ROLL_WIDTH-1:0] r2_reg, r2_next;
    logic [31:0]                    t3_reg, t3_next;
    logic [31:0]                    t4_reg, t4_next;
    logic [31:0]                    step_one;
    logic [31:0]                    step_two;

    assign step_one = 32'(t4_reg * pfi_pkg::LCG_MUL) + pfi_pkg::LCG_INC;
    assign step_two = 32'(t4_reg * pfi_pkg::LCG_MUL2) + pfi_pkg::LCG_INC2;

    always_comb
    begin
        r1_next = r1_reg;
        r2_next = r2_reg;
        t3_next = t3_reg;
        t4_next = t4_reg;
        case (draw_count)
            2'd1:
            begin
                r1_next = r2_reg;
                r2_next = pfi_pkg::roll_of(t3_reg);
                t3_next = t4_reg;
                t4_next = step_one;
            end
            2'd2:
            begin
                r1_next = pfi_pkg::roll_of(t3_reg);
                r2_next = pfi_pkg::roll_of(t4_reg);
                t3_next = step_one;
                t4_next = step_two;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r1_reg <= pfi_pkg::ROLL1_INIT;
            r2_reg <= pfi_pkg::ROLL2_INIT;
            t3_reg <= pfi_pkg::LCG_S3;
            t4_reg <= pfi_pkg::LCG_S4;
        end
        else
        begin
            r1_reg <= r1_next;
            r2_reg <= r2_next;
            t3_reg <= t3_next;
            t4_reg <= t4_next;
        end
    end

    assign rolls.roll_first  = r1_reg;
    assign rolls.roll_second = r2_reg;

endmodule

### hdl/probabilistic_fault_injector.sv
// ----------------------------------------------------------------------------
// probabilistic_fault_injector: fault decision for memory-access hook events
// Decides per event whether its fault kind fires, applies the fault to the
// data, and keeps fire counts and a running total.
//
//  channel | direction | payload        | transfer when
//  in      | input     | pfi_pkg::in_t  | in_valid & in_ready
//  out     | output    | pfi_pkg::out_t | out_valid & out_ready
//  cfg     | input     | index, data    | cfg_valid & cfg_ready (always ready)
//
// One event per cycle while in_ready is high; each result is registered and appears in the cycle after its transfer.
// Up to two LCG draws per event come from a look-ahead roll queue.
// An output register holds the result; in_ready stays high while it is
// empty or being taken. Reset restores seed, counts and setup registers.
// ----------------------------------------------------------------------------
module probabilistic_fault_injector #(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  pfi_pkg::in_t                          in_item,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output pfi_pkg::out_t                         out_item,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [pfi_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [pfi_pkg::CFG_DATA_WIDTH-1:0]    cfg_data
);

    logic [31:0]            setup_reg [pfi_pkg::NUM_FAULTS];
    logic [COUNT_WIDTH-1:0] count_reg [pfi_pkg::NUM_FAULTS];
    logic [31:0]            total_reg;
    logic                   out_valid_reg;
    pfi_pkg::out_t          out_item_reg, out_item_next;

    pfi_pkg::roll_pair_t           rolls;
    logic [1:0]                    draws;
    logic [1:0]                    draw_count;
    logic [pfi_pkg::NUM_FAULTS-1:0] fire;
    logic                          accept;
    logic                          cfg_write;
    logic                          any_fire;
    logic                          e0, e1, d0, d1, f0;
    logic [pfi_pkg::ROLL_WIDTH-1:0] roll_b;
    logic [7:0]                    target;
    logic [31:0]                   byte_mask;

    function automatic logic eligible(logic [31:0] setup, logic [COUNT_WIDTH-1:0] count);
        logic [15:0] limit;
        limit = setup[23:8];
        return setup[0] && ((limit == 16'd0) || (32'(count) < 32'(limit)));
    endfunction

    function automatic logic needs_draw(logic [31:0] setup);
        return setup[7:1] != 7'd0;
    endfunction

    function automatic logic pass_roll(logic [31:0] setup, logic [pfi_pkg::ROLL_WIDTH-1:0] roll);
        logic [10:0] thr;
        thr = 11'(setup[7:1]) * 11'd10;
        return (setup[7:1] == 7'd0) || (11'(roll) < thr);
    endfunction

    function automatic logic [31:0] low_bytes_mask(logic [15:0] len);
        logic [31:0] m;
        if (len >= 16'd4)
        begin
            m = 32'hFFFF_FFFF;
        end
        else
        begin
            case (len[1:0])
                2'd1:    m = 32'h0000_00FF;
                2'd2:    m = 32'h0000_FFFF;
                2'd3:    m = 32'h00FF_FFFF;
                default: m = 32'h0000_0000;
            endcase
        end
        return m;
    endfunction

    assign in_ready   = !out_valid_reg || out_ready;
    assign accept     = in_valid && in_ready;
    assign cfg_ready  = 1'b1;
    assign cfg_write  = cfg_valid && cfg_ready;
    assign draw_count = accept ? draws : 2'd0;
    assign byte_mask  = low_bytes_mask(in_item.length);
    assign target     = setup_reg[pfi_pkg::FAULT_RAM][31:24];

    pfi_rng u_rng
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .draw_count (draw_count),
        .rolls      (rolls)
    );

    always_comb
    begin
        fire   = '0;
        draws  = 2'd0;
        e0     = eligible(setup_reg[pfi_pkg::FAULT_SINGLE], count_reg[pfi_pkg::FAULT_SINGLE]);
        e1     = eligible(setup_reg[pfi_pkg::FAULT_MULTI], count_reg[pfi_pkg::FAULT_MULTI]);
        d0     = e0 && needs_draw(setup_reg[pfi_pkg::FAULT_SINGLE]);
        f0     = e0 && pass_roll(setup_reg[pfi_pkg::FAULT_SINGLE], rolls.roll_first);
        roll_b = d0 ? rolls.roll_second : rolls.roll_first;
        d1     = !f0 && e1 && needs_draw(setup_reg[pfi_pkg::FAULT_MULTI]);
        unique case (in_item.mode)
            pfi_pkg::MODE_AFTER_READ:
            begin
                if (in_item.length != 16'd0)
                begin
                    fire[pfi_pkg::FAULT_SINGLE] = f0;
                    fire[pfi_pkg::FAULT_MULTI]  = !f0 && e1
                        && pass_roll(setup_reg[pfi_pkg::FAULT_MULTI], roll_b);
                    draws = 2'({1'b0, d0} + {1'b0, d1});
                end
            end
            pfi_pkg::MODE_BEFORE_WRITE:
            begin
                fire[pfi_pkg::FAULT_ERASE] =
                    eligible(setup_reg[pfi_pkg::FAULT_ERASE], count_reg[pfi_pkg::FAULT_ERASE])
                    && pass_roll(setup_reg[pfi_pkg::FAULT_ERASE], rolls.roll_first);
                draws = {1'b0,
                    eligible(setup_reg[pfi_pkg::FAULT_ERASE], count_reg[pfi_pkg::FAULT_ERASE])
                    && needs_draw(setup_reg[pfi_pkg::FAULT_ERASE])};
            end
            pfi_pkg::MODE_AFTER_WRITE:
            begin
                fire[pfi_pkg::FAULT_POWER] =
                    eligible(setup_reg[pfi_pkg::FAULT_POWER], count_reg[pfi_pkg::FAULT_POWER])
                    && pass_roll(setup_reg[pfi_pkg::FAULT_POWER], rolls.roll_first);
                draws = {1'b0,
                    eligible(setup_reg[pfi_pkg::FAULT_POWER], count_reg[pfi_pkg::FAULT_POWER])
                    && needs_draw(setup_reg[pfi_pkg::FAULT_POWER])};
            end
            pfi_pkg::MODE_CRC:
            begin
                fire[pfi_pkg::FAULT_CRC] =
                    eligible(setup_reg[pfi_pkg::FAULT_CRC], count_reg[pfi_pkg::FAULT_CRC])
                    && pass_roll(setup_reg[pfi_pkg::FAULT_CRC], rolls.roll_first);
                draws = {1'b0,
                    eligible(setup_reg[pfi_pkg::FAULT_CRC], count_reg[pfi_pkg::FAULT_CRC])
                    && needs_draw(setup_reg[pfi_pkg::FAULT_CRC])};
            end
            pfi_pkg::MODE_VERIFY:
            begin
                fire[pfi_pkg::FAULT_VERIFY] =
                    eligible(setup_reg[pfi_pkg::FAULT_VERIFY], count_reg[pfi_pkg::FAULT_VERIFY])
                    && pass_roll(setup_reg[pfi_pkg::FAULT_VERIFY], rolls.roll_first);
                draws = {1'b0,
                    eligible(setup_reg[pfi_pkg::FAULT_VERIFY], count_reg[pfi_pkg::FAULT_VERIFY])
                    && needs_draw(setup_reg[pfi_pkg::FAULT_VERIFY])};
            end
            pfi_pkg::MODE_RAM_MIRROR:
            begin
                if (in_item.length != 16'd0)
                begin
                    fire[pfi_pkg::FAULT_RAM] =
                        eligible(setup_reg[pfi_pkg::FAULT_RAM], count_reg[pfi_pkg::FAULT_RAM])
                        && pass_roll(setup_reg[pfi_pkg::FAULT_RAM], rolls.roll_first)
                        && ((target == pfi_pkg::ANY_BLOCK) || (target == in_item.block_num));
                    draws = {1'b0,
                        eligible(setup_reg[pfi_pkg::FAULT_RAM], count_reg[pfi_pkg::FAULT_RAM])
                        && needs_draw(setup_reg[pfi_pkg::FAULT_RAM])};
                end
            end
            default:
            begin
            end
        endcase
    end

    assign any_fire = |fire;

    always_comb
    begin
        out_item_next.injected    = any_fire;
        out_item_next.data_out    = in_item.data_in;
        out_item_next.crc_out     = in_item.crc_in;
        out_item_next.actual_out  = 8'd0;
        out_item_next.fill_all    = fire[pfi_pkg::FAULT_RAM];
        out_item_next.fault_total = total_reg + 32'(any_fire);
        if (fire[pfi_pkg::FAULT_SINGLE])
        begin
            out_item_next.data_out = in_item.data_in ^ 32'h0000_0001;
        end
        else if (fire[pfi_pkg::FAULT_MULTI])
        begin
            out_item_next.data_out = in_item.data_in ^ byte_mask;
        end
        else if (fire[pfi_pkg::FAULT_RAM])
        begin
            out_item_next.data_out = (in_item.data_in & ~byte_mask)
                                   | (pfi_pkg::FILL_PATTERN & byte_mask);
        end
        if (fire[pfi_pkg::FAULT_CRC])
        begin
            out_item_next.crc_out = ~in_item.crc_in;
        end
        if (fire[pfi_pkg::FAULT_VERIFY] && (in_item.length != 16'd0))
        begin
            out_item_next.actual_out = ~in_item.expected_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < pfi_pkg::NUM_FAULTS; k++)
            begin
                setup_reg[k] <= (k == int'(pfi_pkg::FAULT_RAM)) ? pfi_pkg::RAM_SETUP_RESET
                                                                 : '0;
                count_reg[k] <= '0;
            end
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            for (int k = 0; k < pfi_pkg::NUM_FAULTS; k++)
            begin
                if (cfg_write && (cfg_index == pfi_pkg::CFG_INDEX_WIDTH'(k)))
                begin
                    if (k == int'(pfi_pkg::FAULT_RAM))
                    begin
                        setup_reg[k] <= cfg_data;
                    end
                    else
                    begin
                        setup_reg[k] <= cfg_data & pfi_pkg::SETUP_MASK_SHORT;
                    end
                    count_reg[k] <= '0;
                end
                else if (accept && fire[k])
                begin
                    count_reg[k] <= count_reg[k] + COUNT_WIDTH'(1);
                end
            end
            if (accept)
            begin
                total_reg     <= out_item_next.fault_total;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("in_ready low with empty output register");

    a_one_fire: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(fire))
        else $error("more than one fault fired for one event");

    a_draws_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (draws != 2'd3) && ((draws != 2'd2) || (in_item.mode == pfi_pkg::MODE_AFTER_READ)))
        else $error("illegal draw count");

    a_total_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (total_reg == out_item_reg.fault_total)
                   && (total_reg == $past(total_reg) + 32'($past(any_fire))))
        else $error("running total out of step with result");

    a_fill_injected: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.fill_all |-> out_item_reg.injected)
        else $error("fill without injection");

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the probabilistic fault injector
// Drives hook events and setup writes through valid/ready channels. A
// scoreboard predicts each result, including the pseudo-random draws and the
// per-fault trigger limits, and checks every result transfer in order.
// Directed events open the run, then random phases follow under extreme and
// mixed setups, with bursty sending and patterned output stalls.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int          COUNT_W         = 16;
    localparam int          SETTLE_CYCLES   = 4;
    localparam int          RAND_PHASES     = 10;
    localparam int          PHASE_EVENTS    = 200;
    localparam int          LIMIT_NS        = 1_000_000;
    localparam logic [2:0]  MODE_SPARE_LO   = 3'd6;
    localparam logic [2:0]  MODE_SPARE_HI   = 3'd7;
    localparam logic [pfi_pkg::CFG_INDEX_WIDTH-1:0] CFG_SPARE_INDEX = 3'd7;

    typedef enum {SETUP_MAX, SETUP_ZERO, SETUP_MIXED} setup_style_e;
    typedef enum {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_PERIODIC} ready_style_e;

    class injector_scoreboard;
        logic [31:0]        setup [pfi_pkg::NUM_FAULTS];
        logic [COUNT_W-1:0] fire_count [pfi_pkg::NUM_FAULTS];
        logic [31:0]        lcg;
        logic [31:0]        total;
        pfi_pkg::out_t      awaited [$];
        int                 errors;
        int                 events;
        int                 fired;

        function new();
            for (int k = 0; k < pfi_pkg::NUM_FAULTS; k++)
            begin
                setup[k]      = '0;
                fire_count[k] = '0;
            end
            setup[pfi_pkg::FAULT_RAM] = pfi_pkg::RAM_SETUP_RESET;
            lcg    = pfi_pkg::LCG_SEED;
            total  = '0;
            errors = 0;
            events = 0;
            fired  = 0;
        endfunction

        function void write_setup(logic [pfi_pkg::CFG_INDEX_WIDTH-1:0] idx, logic [31:0] val);
            if (idx >= pfi_pkg::NUM_FAULTS)
                return;
            setup[idx]      = (idx == pfi_pkg::FAULT_RAM) ? val : {8'h00, val[23:0]};
            fire_count[idx] = '0;
        endfunction

        function int unsigned next_roll();
            lcg = lcg * pfi_pkg::LCG_MUL + pfi_pkg::LCG_INC;
            return lcg[31:16] % 16'd1000;
        endfunction

        function bit fault_fires(int k);
            logic [31:0] r;
            int unsigned prob;
            int unsigned limit;
            r     = setup[k];
            prob  = r[7:1];
            limit = r[23:8];
            if (!r[0])
                return 1'b0;
            if (limit != 0 && fire_count[k] >= limit)
                return 1'b0;
            if (prob == 0)
                return 1'b1;
            return next_roll() < prob * 10;
        endfunction

        function void bump(int k);
            fire_count[k] = fire_count[k] + 1'b1;
            total         = total + 32'd1;
            fired++;
        endfunction

        function logic [31:0] byte_mask(logic [15:0] len);
            if (len >= 16'd4)
                return 32'hFFFF_FFFF;
            return (32'd1 << (8 * len)) - 32'd1;
        endfunction

        function void note_event(pfi_pkg::in_t it);
            pfi_pkg::out_t e;
            logic [31:0]   m;
            logic [7:0]    tgt;
            e            = '0;
            e.data_out   = it.data_in;
            e.crc_out    = it.crc_in;
            case (it.mode)
                pfi_pkg::MODE_AFTER_READ:
                    if (it.length != 0)
                    begin
                        if (fault_fires(pfi_pkg::FAULT_SINGLE))
                        begin
                            e.data_out = e.data_out ^ 32'h1;
                            bump(pfi_pkg::FAULT_SINGLE);
                            e.injected = 1'b1;
                        end
                        else if (fault_fires(pfi_pkg::FAULT_MULTI))
                        begin
                            e.data_out = e.data_out ^ byte_mask(it.length);
                            bump(pfi_pkg::FAULT_MULTI);
                            e.injected = 1'b1;
                        end
                    end
                pfi_pkg::MODE_BEFORE_WRITE:
                    if (fault_fires(pfi_pkg::FAULT_ERASE))
                    begin
                        bump(pfi_pkg::FAULT_ERASE);
                        e.injected = 1'b1;
                    end
                pfi_pkg::MODE_AFTER_WRITE:
                    if (fault_fires(pfi_pkg::FAULT_POWER))
                    begin
                        bump(pfi_pkg::FAULT_POWER);
                        e.injected = 1'b1;
                    end
                pfi_pkg::MODE_CRC:
                    if (fault_fires(pfi_pkg::FAULT_CRC))
                    begin
                        e.crc_out = ~it.crc_in;
                        bump(pfi_pkg::FAULT_CRC);
                        e.injected = 1'b1;
                    end
                pfi_pkg::MODE_VERIFY:
                    if (fault_fires(pfi_pkg::FAULT_VERIFY))
                    begin
                        if (it.length != 0)
                            e.actual_out = ~it.expected_byte;
                        bump(pfi_pkg::FAULT_VERIFY);
                        e.injected = 1'b1;
                    end
                pfi_pkg::MODE_RAM_MIRROR:
                    if (it.length != 0 && fault_fires(pfi_pkg::FAULT_RAM))
                    begin
                        tgt = setup[pfi_pkg::FAULT_RAM][31:24];
                        if (tgt == pfi_pkg::ANY_BLOCK || tgt == it.block_num)
                        begin
                            m          = byte_mask(it.length);
                            e.data_out = (e.data_out & ~m) | (pfi_pkg::FILL_PATTERN & m);
                            e.fill_all = 1'b1;
                            bump(pfi_pkg::FAULT_RAM);
                            e.injected = 1'b1;
                        end
                    end
                default:
                    ;
            endcase
            e.fault_total = total;
            awaited.push_back(e);
            events++;
        endfunction

        function void check_result(pfi_pkg::out_t got);
            pfi_pkg::out_t want;
            if (awaited.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: result with none awaited: %h", got);
                return;
            end
            want = awaited.pop_front();
            if (got.injected !== want.injected || got.data_out !== want.data_out
                || got.crc_out !== want.crc_out || got.actual_out !== want.actual_out
                || got.fill_all !== want.fill_all
                || got.fault_total !== want.fault_total)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("ERROR: want inj=%b data=%h crc=%h act=%h fill=%b total=%0d",
                             want.injected, want.data_out, want.crc_out, want.actual_out,
                             want.fill_all, want.fault_total);
                    $display("       got  inj=%b data=%h crc=%h act=%h fill=%b total=%0d",
                             got.injected, got.data_out, got.crc_out, got.actual_out,
                             got.fill_all, got.fault_total);
                end
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic                                 clk;
    logic                                 rst_n      = 1'b0;
    logic                                 in_valid   = 1'b0;
    logic                                 in_ready;
    pfi_pkg::in_t                         in_item    = '0;
    logic                                 out_valid;
    logic                                 out_ready  = 1'b0;
    pfi_pkg::out_t                        out_item;
    logic                                 cfg_valid  = 1'b0;
    logic                                 cfg_ready;
    logic [pfi_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index  = '0;
    logic [pfi_pkg::CFG_DATA_WIDTH-1:0]   cfg_data   = '0;

    injector_scoreboard model = new();
    int           burst_left   = 6;
    int           setup_writes = 0;
    ready_style_e ready_style  = READY_ALWAYS;
    int           ready_left   = 30;
    int unsigned  cycle_count  = 0;

    probabilistic_fault_injector #(
        .COUNT_WIDTH (COUNT_W)
    )
    dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #(LIMIT_NS);
        $display("timeout with %0d results outstanding", model.pending());
        $display("end of test: mismatches");
        $finish;
    end

    always @(posedge clk)
    begin
        if (in_valid && in_ready)
            model.note_event(in_item);
        if (out_valid && out_ready)
            model.check_result(out_item);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (ready_left == 0)
        begin
            ready_style <= ready_style_e'($urandom_range(0, 3));
            ready_left  <= $urandom_range(20, 120);
        end
        else
        begin
            ready_left <= ready_left - 1;
        end
        case (ready_style)
            READY_ALWAYS:   out_ready <= 1'b1;
            READY_COIN:     out_ready <= 1'($urandom_range(0, 1));
            READY_SPARSE:   out_ready <= ($urandom_range(0, 3) == 0);
            default:        out_ready <= (cycle_count % 5) != 0;
        endcase
    end

    function automatic pfi_pkg::in_t make_event(logic [2:0] mode, logic [31:0] data,
                                                logic [15:0] len, logic [15:0] crc,
                                                logic [7:0] expb, logic [7:0] blk);
        pfi_pkg::in_t it;
        it.mode          = mode;
        it.data_in       = data;
        it.length        = len;
        it.crc_in        = crc;
        it.expected_byte = expb;
        it.block_num     = blk;
        return it;
    endfunction

    function automatic logic [31:0] pack_setup(bit en, logic [6:0] prob, logic [15:0] limit,
                                               logic [7:0] tgt);
        return {tgt, limit, prob, en};
    endfunction

    function automatic logic [31:0] random_setup();
        logic [6:0]  prob;
        logic [15:0] limit;
        logic [7:0]  tgt;
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        case ($urandom_range(0, 3))
            0:       prob = 7'd0;
            1:       prob = 7'($urandom_range(1, 99));
            2:       prob = 7'($urandom_range(100, 127));
            default: prob = 7'($urandom_range(1, 20));
        endcase
        case ($urandom_range(0, 2))
            0:       limit = 16'd0;
            1:       limit = 16'($urandom_range(1, 6));
            default: limit = 16'($urandom);
        endcase
        tgt = ($urandom_range(0, 2) == 0) ? pfi_pkg::ANY_BLOCK : 8'($urandom_range(0, 3));
        return pack_setup($urandom_range(0, 4) != 0, prob, limit, tgt);
    endfunction

    function automatic pfi_pkg::in_t random_event();
        pfi_pkg::in_t it;
        it.data_in       = $urandom;
        it.crc_in        = 16'($urandom);
        it.expected_byte = 8'($urandom);
        if ($urandom_range(0, 19) == 0)
            it.mode = 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
        else
            it.mode = 3'($urandom_range(pfi_pkg::MODE_AFTER_READ, pfi_pkg::MODE_RAM_MIRROR));
        case ($urandom_range(0, 9))
            0:             it.length = 16'd0;
            1, 2, 3, 4, 5: it.length = 16'($urandom_range(1, 5));
            default:       it.length = 16'($urandom);
        endcase
        if ($urandom_range(0, 3) != 0)
            it.block_num = 8'($urandom_range(0, 3));
        else
            it.block_num = 8'($urandom);
        return it;
    endfunction

    task automatic write_setup_reg(input logic [pfi_pkg::CFG_INDEX_WIDTH-1:0] idx,
                                   input logic [31:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        model.write_setup(idx, val);
        setup_writes++;
    endtask

    task automatic program_setups(input setup_style_e style);
        for (int k = 0; k < pfi_pkg::NUM_FAULTS; k++)
        begin
            write_setup_reg(pfi_pkg::CFG_INDEX_WIDTH'(k),
                            style == SETUP_MAX  ? 32'hFFFF_FFFF :
                            style == SETUP_ZERO ? 32'd0 : random_setup());
        end
        if (style != SETUP_MIXED || $urandom_range(0, 1) == 1)
            write_setup_reg(CFG_SPARE_INDEX, $urandom);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_event(input pfi_pkg::in_t it);
        in_item  <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        burst_left--;
        if (burst_left <= 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8))
                @(posedge clk);
            case ($urandom_range(0, 3))
                0:       burst_left = $urandom_range(1, 3);
                1, 2:    burst_left = $urandom_range(4, 24);
                default: burst_left = $urandom_range(60, 150);
            endcase
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (model.pending() != 0);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    initial
    begin
        int pause_at;
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset setup: everything disabled
        send_event(make_event(pfi_pkg::MODE_AFTER_READ, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
                              8'hFF, 8'hFF));
        send_event(make_event(pfi_pkg::MODE_RAM_MIRROR, 32'h0, 16'd1, 16'h0, 8'h00, 8'hFF));
        send_event(make_event(MODE_SPARE_HI, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF));
        drain_results();

        write_setup_reg(pfi_pkg::FAULT_SINGLE, pack_setup(1'b1, 7'd0, 16'd2, 8'h00));
        write_setup_reg(pfi_pkg::FAULT_MULTI,  pack_setup(1'b1, 7'd0, 16'd0, 8'h00));
        write_setup_reg(pfi_pkg::FAULT_ERASE,  pack_setup(1'b1, 7'd0, 16'd1, 8'h00));
        write_setup_reg(pfi_pkg::FAULT_POWER,  pack_setup(1'b1, 7'd100, 16'd0, 8'h00));
        write_setup_reg(pfi_pkg::FAULT_CRC,    pack_setup(1'b1, 7'd127, 16'hFFFF, 8'h00));
        write_setup_reg(pfi_pkg::FAULT_VERIFY, pack_setup(1'b1, 7'd0, 16'd0, 8'h00));
        write_setup_reg(pfi_pkg::FAULT_RAM,    pack_setup(1'b1, 7'd0, 16'd0, 8'd5));
        write_setup_reg(CFG_SPARE_INDEX, 32'hFFFF_FFFF);
        cfg_valid <= 1'b0;

        // single until its limit, then multi over each byte count
        send_event(make_event(pfi_pkg::MODE_AFTER_READ, 32'h0000_0000, 16'd1, 16'h0,
                              8'h00, 8'h00));
        send_event(make_event(pfi_pkg::MODE_AFTER_READ, 32'hFFFF_FFFF, 16'd2, 16'h0,
                              8'h00, 8'h00));
        send_event(make_event(pfi_pkg::MODE_AFTER_READ, 32'h1234_5678, 16'd3, 16'h0,
                              8'h00, 8'h00));
        send_event(make_event(pfi_pkg::MODE_AFTER_READ, 32'h1234_5678, 16'd0, 16'h0,
                              8'h00, 8'h00));
        send_event(make_event(pfi_pkg::MODE_AFTER_READ, 32'h8765_4321, 16'd4, 16'h0,
                              8'h00, 8'h00));
        send_event(make_event(pfi_pkg::MODE_AFTER_READ, 32'hA5A5_5A5A, 16'd5, 16'h0,
                              8'h00, 8'h00));
        send_event(make_event(pfi_pkg::MODE_AFTER_READ, 32'h0F0F_F0F0, 16'hFFFF, 16'h0,
                              8'h00, 8'h00));
        send_event(make_event(pfi_pkg::MODE_BEFORE_WRITE, 32'h0, 16'd8, 16'h0, 8'h00, 8'h00));
        send_event(make_event(pfi_pkg::MODE_BEFORE_WRITE, 32'h0, 16'd8, 16'h0, 8'h00, 8'h00));
        send_event(make_event(pfi_pkg::MODE_AFTER_WRITE, 32'h0, 16'd8, 16'h0, 8'h00, 8'h00));
        send_event(make_event(pfi_pkg::MODE_CRC, 32'h0, 16'd8, 16'h0000, 8'h00, 8'h00));
        send_event(make_event(pfi_pkg::MODE_CRC, 32'h0, 16'd8, 16'hFFFF, 8'h00, 8'h00));
        send_event(make_event(pfi_pkg::MODE_VERIFY, 32'h0, 16'd0, 16'h0, 8'hFF, 8'h00));
        send_event(make_event(pfi_pkg::MODE_VERIFY, 32'h0, 16'd1, 16'h0, 8'h00, 8'h00));
        send_event(make_event(pfi_pkg::MODE_VERIFY, 32'h0, 16'hFFFF, 16'h0, 8'hA5, 8'h00));
        send_event(make_event(pfi_pkg::MODE_RAM_MIRROR, 32'h0000_0000, 16'd1, 16'h0,
                              8'h00, 8'd5));
        send_event(make_event(pfi_pkg::MODE_RAM_MIRROR, 32'h1234_5678, 16'd3, 16'h0,
                              8'h00, 8'd4));
        send_event(make_event(pfi_pkg::MODE_RAM_MIRROR, 32'h1234_5678, 16'd0, 16'h0,
                              8'h00, 8'd5));
        send_event(make_event(pfi_pkg::MODE_RAM_MIRROR, 32'hFFFF_FFFF, 16'd8, 16'h0,
                              8'h00, 8'd5));
        send_event(make_event(pfi_pkg::MODE_RAM_MIRROR, 32'hFFFF_FFFF, 16'd8, 16'h0,
                              8'h00, 8'hFF));
        send_event(make_event(MODE_SPARE_LO, 32'h0, 16'd0, 16'h0, 8'h00, 8'h00));
        send_event(make_event(MODE_SPARE_HI, 32'hFFFF_FFFF, 16'd4, 16'hFFFF, 8'hFF, 8'd5));

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            drain_results();
            program_setups(p == 0 ? SETUP_MAX : p == 1 ? SETUP_ZERO : SETUP_MIXED);
            pause_at = $urandom_range(20, PHASE_EVENTS - 20);
            for (int i = 0; i < PHASE_EVENTS; i++)
            begin
                if (i == pause_at)
                    drain_results();
                send_event(random_event());
            end
        end

        drain_results();
        model.errors += model.pending();
        $display("covered %0d hook events in %0d setup phases, %0d faults fired",
                 model.events, RAND_PHASES + 2, model.fired);
        $display("%0d setup writes, %0d result errors", setup_writes, model.errors);
        if (model.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

### filelist.f
hdl/pfi_pkg.sv
hdl/pfi_rng.sv
hdl/probabilistic_fault_injector.sv
sim/tb_top.sv
